// ===== src/tsel_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsel_pkg
// Shared types, sizes and helpers of the time sorted event list.
// ----------------------------------------------------------------------------
package tsel_pkg;

    localparam int DEPTH       = 64;
    localparam int RESULT_CAP  = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int COUNT_OUT_W = 7;
    localparam int RUN_W       = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

    typedef struct packed {
        logic [31:0] ev_time;
        logic [7:0]  player;
        logic [2:0]  action;
        logic [15:0] target;
    } entry_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TAKE   = 2'd1,
        OP_READ   = 2'd2,
        OP_ERASE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_POP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             insert;
        logic             rotate;
        logic [CNT_W-1:0] count;
    } cell_ctl_t;

    // Strict order on time, then player; equal keys do not sort before.
    function automatic logic sorts_before(entry_t a, entry_t b);
        logic res;
        if (a.ev_time != b.ev_time)
        begin
            res = (a.ev_time < b.ev_time);
        end
        else
        begin
            res = (a.player < b.player);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/tsel_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsel_cell
// One slot of the list: holds an entry, shifts right on insert, rotates left.
// ----------------------------------------------------------------------------
module tsel_cell (
    input  wire logic                        clk,
    input  wire tsel_pkg::cell_ctl_t         ctl,
    input  wire logic [tsel_pkg::IDX_W-1:0]  idx,
    input  wire tsel_pkg::entry_t            new_entry,
    input  wire tsel_pkg::entry_t            left_entry,
    input  wire logic                        left_shift,
    input  wire tsel_pkg::entry_t            right_entry,
    output tsel_pkg::entry_t                 entry,
    output logic                             shift
);

    tsel_pkg::entry_t             data_reg;
    tsel_pkg::entry_t             data_next;
    logic [tsel_pkg::CNT_W-1:0]   idx_ext;
    logic                         occupied;
    logic                         later;

    assign idx_ext  = tsel_pkg::CNT_W'(idx);
    assign occupied = (idx_ext < ctl.count);
    assign later    = occupied && tsel_pkg::sorts_before(new_entry, data_reg);
    // The free slot at the end of the list always makes room.
    assign shift    = later || (idx_ext == ctl.count);
    assign entry    = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.insert && shift)
        begin
            data_next = left_shift ? left_entry : new_entry;
        end
        else if (ctl.rotate)
        begin
            data_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== src/tsel_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsel_chain
// Ring of list cells; the head cells are visible to the controller.
// ----------------------------------------------------------------------------
module tsel_chain (
    input  wire logic                clk,
    input  wire tsel_pkg::cell_ctl_t ctl,
    input  wire tsel_pkg::entry_t    new_entry,
    output tsel_pkg::entry_t         head0,
    output tsel_pkg::entry_t         head1
);

    tsel_pkg::entry_t entries [tsel_pkg::DEPTH];
    logic             shifts  [tsel_pkg::DEPTH];

    for (genvar i = 0; i < tsel_pkg::DEPTH; i++)
    begin : g_cell
        tsel_pkg::entry_t left_e;
        tsel_pkg::entry_t right_e;
        logic             left_s;

        if (i == 0)
        begin : g_first
            assign left_e = new_entry;
            assign left_s = 1'b0;
        end
        else
        begin : g_rest
            assign left_e = entries[i-1];
            assign left_s = shifts[i-1];
        end

        // Close the ring so a full turn restores the order.
        assign right_e = entries[(i + 1) % tsel_pkg::DEPTH];

        tsel_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .idx         (tsel_pkg::IDX_W'(i)),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_shift  (left_s),
            .right_entry (right_e),
            .entry       (entries[i]),
            .shift       (shifts[i])
        );
    end

    assign head0 = entries[0];
    assign head1 = entries[1];

endmodule
`default_nettype wire

// ===== src/time_sorted_event_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_sorted_event_list
// Bounded list of events kept in time then player order, with take, read
// and erase queries.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  cmd      cmd_valid/cmd_ready    operation event_time player_id action_kind
//                                  target_id
//  res      res_valid/res_ready    out_time out_player out_action out_target
//                                  no_entry last_of_run status latest_time
//                                  entry_count
//
//  One command is worked at a time. Insert: the entry enters the cell row in
//  ST_INSERT and is acknowledged from ST_DONE. Take, read and erase turn the
//  cell ring once, one cell step a cycle unless a read match stalls; a take
//  then pops one item a cycle, and erase and empty matches acknowledge from
//  ST_DONE. Reset clears count, latest time and handshakes; cell contents are
//  left. A stalled result holds the scan only while a read match waits for
//  space; pops and acknowledges wait for a free result register.
// ----------------------------------------------------------------------------
module time_sorted_event_list (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] event_time,
    input  wire logic [7:0]  player_id,
    input  wire logic [2:0]  action_kind,
    input  wire logic [15:0] target_id,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [31:0]      out_time,
    output logic [7:0]       out_player,
    output logic [2:0]       out_action,
    output logic [15:0]      out_target,
    output logic             no_entry,
    output logic             last_of_run,
    output logic             status,
    output logic [31:0]      latest_time,
    output logic [6:0]       entry_count
);

    localparam int CW = tsel_pkg::CNT_W;
    localparam int RW = tsel_pkg::RUN_W;
    localparam int IW = tsel_pkg::IDX_W;
    localparam int OW = tsel_pkg::COUNT_OUT_W;

    // control
    tsel_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [31:0]        latest_reg, latest_next;
    logic               res_valid_reg, res_valid_next;
    logic [IW-1:0]      step_reg, step_next;
    logic [RW-1:0]      n_reg, n_next;
    logic               prefix_reg, prefix_next;
    logic               status_reg, status_next;

    // payload
    tsel_pkg::op_t      op_reg, op_next;
    logic [31:0]        qt_reg, qt_next;
    tsel_pkg::entry_t   new_reg, new_next;
    logic [31:0]        last_t_reg, last_t_next;
    tsel_pkg::entry_t   res_entry_reg, res_entry_next;
    logic               res_none_reg, res_none_next;
    logic               res_last_reg, res_last_next;
    logic               res_status_reg, res_status_next;
    logic [31:0]        res_latest_reg, res_latest_next;
    logic [OW-1:0]      res_count_reg, res_count_next;

    tsel_pkg::cell_ctl_t ctl;
    tsel_pkg::entry_t    head0, head1;

    logic               slot_free;
    logic [CW-1:0]      k_ext;
    logic               k_valid;
    logic               cap_ok;
    logic               take_hit, erase_hit, read_hit;
    logic               hit;
    logic               advance;
    logic               step_last;
    logic [RW-1:0]      n_after;
    logic               read_more;
    logic               full;
    logic [CW+OW-1:0]   cnt_wide;
    logic [CW-1:0]      remain;

    assign slot_free = !res_valid_reg || res_ready;
    assign k_ext     = CW'(step_reg);
    assign k_valid   = (k_ext < count_reg);
    assign cap_ok    = (n_reg < RW'(tsel_pkg::RESULT_CAP));
    assign take_hit  = (op_reg == tsel_pkg::OP_TAKE) && k_valid && prefix_reg
                       && (head0.ev_time <= qt_reg) && cap_ok;
    assign erase_hit = (op_reg == tsel_pkg::OP_ERASE) && k_valid && prefix_reg
                       && (head0.ev_time <= qt_reg);
    assign read_hit  = (op_reg == tsel_pkg::OP_READ) && k_valid
                       && (head0.ev_time == qt_reg) && cap_ok;
    assign hit       = take_hit || erase_hit || read_hit;
    assign advance   = (state_reg == tsel_pkg::ST_SCAN) && (!read_hit || slot_free);
    assign step_last = (step_reg == IW'(tsel_pkg::DEPTH - 1));
    assign n_after   = hit ? RW'(n_reg + RW'(1)) : n_reg;
    // Equal times sit together, so the next cell tells whether the run goes on.
    assign read_more = ((k_ext + CW'(1)) < count_reg) && (head1.ev_time == qt_reg);
    assign full      = (count_reg == CW'(tsel_pkg::DEPTH));
    assign cnt_wide  = {OW'(0), count_reg};
    assign remain    = count_reg - n_after[CW-1:0];

    assign cmd_ready   = (state_reg == tsel_pkg::ST_IDLE);
    assign res_valid   = res_valid_reg;
    assign out_time    = res_entry_reg.ev_time;
    assign out_player  = res_entry_reg.player;
    assign out_action  = res_entry_reg.action;
    assign out_target  = res_entry_reg.target;
    assign no_entry    = res_none_reg;
    assign last_of_run = res_last_reg;
    assign status      = res_status_reg;
    assign latest_time = res_latest_reg;
    assign entry_count = res_count_reg;

    tsel_chain u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .new_entry (new_reg),
        .head0     (head0),
        .head1     (head1)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsel_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (tsel_pkg::op_t'(operation) == tsel_pkg::OP_INSERT)
                                 ? tsel_pkg::ST_INSERT : tsel_pkg::ST_SCAN;
                end
            end
            tsel_pkg::ST_INSERT:
            begin
                state_next = tsel_pkg::ST_DONE;
            end
            tsel_pkg::ST_SCAN:
            begin
                if (advance && step_last)
                begin
                    unique case (op_reg)
                        tsel_pkg::OP_TAKE:
                            state_next = (n_after != '0) ? tsel_pkg::ST_POP
                                                         : tsel_pkg::ST_DONE;
                        tsel_pkg::OP_READ:
                            state_next = (n_after != '0) ? tsel_pkg::ST_IDLE
                                                         : tsel_pkg::ST_DONE;
                        tsel_pkg::OP_ERASE,
                        tsel_pkg::OP_INSERT:
                            state_next = tsel_pkg::ST_DONE;
                    endcase
                end
            end
            tsel_pkg::ST_POP:
            begin
                if (slot_free && (n_reg == RW'(1)))
                begin
                    state_next = tsel_pkg::ST_IDLE;
                end
            end
            tsel_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = tsel_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsel_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next      = count_reg;
        latest_next     = latest_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        step_next       = step_reg;
        n_next          = n_reg;
        prefix_next     = prefix_reg;
        status_next     = status_reg;
        op_next         = op_reg;
        qt_next         = qt_reg;
        new_next        = new_reg;
        last_t_next     = last_t_reg;
        res_entry_next  = res_entry_reg;
        res_none_next   = res_none_reg;
        res_last_next   = res_last_reg;
        res_status_next = res_status_reg;
        res_latest_next = res_latest_reg;
        res_count_next  = res_count_reg;
        ctl.insert      = 1'b0;
        ctl.rotate      = 1'b0;
        ctl.count       = count_reg;

        unique case (state_reg)
            tsel_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next        = tsel_pkg::op_t'(operation);
                    qt_next        = event_time;
                    new_next       = '{ev_time: event_time, player: player_id,
                                       action: action_kind, target: target_id};
                    step_next      = '0;
                    n_next         = '0;
                    prefix_next    = 1'b1;
                    status_next    = 1'b0;
                end
            end
            tsel_pkg::ST_INSERT:
            begin
                if (full)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    ctl.insert = 1'b1;
                    count_next = count_reg + CW'(1);
                    if ((count_reg == '0) || (new_reg.ev_time > latest_reg))
                    begin
                        latest_next = new_reg.ev_time;
                    end
                end
            end
            tsel_pkg::ST_SCAN:
            begin
                if (advance)
                begin
                    ctl.rotate = 1'b1;
                    step_next  = IW'(step_reg + IW'(1));
                    n_next     = n_after;
                    if (!take_hit && !erase_hit)
                    begin
                        prefix_next = 1'b0;
                    end
                    if (erase_hit)
                    begin
                        last_t_next = head0.ev_time;
                    end
                    if (read_hit)
                    begin
                        res_valid_next  = 1'b1;
                        res_entry_next  = head0;
                        res_none_next   = 1'b0;
                        res_last_next   = (n_after == RW'(tsel_pkg::RESULT_CAP)) || !read_more;
                        res_status_next = 1'b0;
                        res_latest_next = latest_reg;
                        res_count_next  = cnt_wide[OW-1:0];
                    end
                    if (step_last)
                    begin
                        // Commit the new length once the whole ring has passed.
                        if (op_reg == tsel_pkg::OP_TAKE)
                        begin
                            count_next  = remain;
                            latest_next = (remain != '0) ? latest_reg : 32'd0;
                        end
                        else if (op_reg == tsel_pkg::OP_ERASE)
                        begin
                            count_next  = n_after[CW-1:0];
                            if (n_after == '0)
                            begin
                                latest_next = 32'd0;
                            end
                            else
                            begin
                                latest_next = erase_hit ? head0.ev_time : last_t_reg;
                            end
                        end
                    end
                end
            end
            tsel_pkg::ST_POP:
            begin
                if (slot_free)
                begin
                    ctl.rotate      = 1'b1;
                    n_next          = n_reg - RW'(1);
                    res_valid_next  = 1'b1;
                    res_entry_next  = head0;
                    res_none_next   = 1'b0;
                    res_last_next   = (n_reg == RW'(1));
                    res_status_next = 1'b0;
                    res_latest_next = latest_reg;
                    res_count_next  = cnt_wide[OW-1:0];
                end
            end
            tsel_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    res_entry_next  = '0;
                    res_none_next   = 1'b1;
                    res_last_next   = 1'b1;
                    res_status_next = status_reg;
                    res_latest_next = latest_reg;
                    res_count_next  = cnt_wide[OW-1:0];
                end
            end
            default:
            begin
                res_valid_next = res_valid_reg && !res_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsel_pkg::ST_IDLE;
            count_reg     <= '0;
            latest_reg    <= '0;
            res_valid_reg <= 1'b0;
            step_reg      <= '0;
            n_reg         <= '0;
            prefix_reg    <= 1'b0;
            status_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            latest_reg    <= latest_next;
            res_valid_reg <= res_valid_next;
            step_reg      <= step_next;
            n_reg         <= n_next;
            prefix_reg    <= prefix_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        qt_reg         <= qt_next;
        new_reg        <= new_next;
        last_t_reg     <= last_t_next;
        res_entry_reg  <= res_entry_next;
        res_none_reg   <= res_none_next;
        res_last_reg   <= res_last_next;
        res_status_reg <= res_status_next;
        res_latest_reg <= res_latest_next;
        res_count_reg  <= res_count_next;
    end

    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(tsel_pkg::DEPTH))
        else $error("list length beyond depth");

    a_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsel_pkg::ST_POP) |-> (n_reg != '0))
        else $error("pop state with nothing left to pop");

    a_refusal_form: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_status_reg) |-> (res_none_reg && res_last_reg))
        else $error("refused insert result carries an entry or is not last");

    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !step_last) |=> (step_reg == IW'($past(step_reg) + IW'(1))))
        else $error("ring step counter out of order");

endmodule
`default_nettype wire

// ===== tb/tb_time_sorted_event_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_time_sorted_event_list
// Self-checking bench for the time sorted event list. A short scripted run
// covers the empty list, both ends of the time range, ties and stable order,
// empty matches and the repair of the latest time. Random episodes follow:
// game-like traffic around a drifting time base, fills up to a full list with
// refused inserts and full drains, plus some noise. Every result item is
// checked field by field against a shadow list, or the script for typed rows.
// ----------------------------------------------------------------------------
module tb_time_sorted_event_list;

    import tsel_pkg::*;

    localparam int          HALF_PERIOD  = 4;
    localparam int          RESET_CYCLES = 10;
    localparam int          MAX_GAP      = 18;
    localparam int          RANDOM_ITEMS = 270;
    localparam int          STUCK_LIMIT  = 2000;
    localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic [2:0] ACT_NONE         = 3'd0;
    localparam logic [2:0] ACT_SPAWN        = 3'd1;
    localparam logic [2:0] ACT_SKILL        = 3'd2;
    localparam logic [2:0] ACT_AIM          = 3'd3;
    localparam logic [2:0] ACT_NUKE         = 3'd4;
    localparam logic [2:0] ACT_ASSIGN_ANY   = 3'd5;
    localparam logic [2:0] ACT_ASSIGN_LEFT  = 3'd6;
    localparam logic [2:0] ACT_ASSIGN_RIGHT = 3'd7;

    typedef struct packed {
        entry_t      ent;
        logic        no_entry;
        logic        last;
        logic        status;
        logic [31:0] latest;
        logic [6:0]  count;
    } outcome_t;

    // One scripted command; typed rows carry their single acknowledge.
    typedef struct packed {
        op_t         op;
        logic [31:0] ev_time;
        logic [7:0]  player;
        logic [2:0]  action;
        logic [15:0] target;
        logic        typed;
        logic        status;
        logic [31:0] latest;
        logic [6:0]  count;
    } script_row_t;

    localparam int SCRIPT_LEN = 21;
    localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
        '{OP_TAKE,   32'd5,    8'd0,   ACT_NONE,         16'h0000, 1'b1, STATUS_OK, 32'd0,    7'd0},
        '{OP_READ,   32'd0,    8'd0,   ACT_NONE,         16'h0000, 1'b1, STATUS_OK, 32'd0,    7'd0},
        '{OP_ERASE,  TIME_MAX, 8'd0,   ACT_NONE,         16'h0000, 1'b1, STATUS_OK, 32'd0,    7'd0},
        '{OP_INSERT, 32'd100,  8'd3,   ACT_SPAWN,        16'h1234, 1'b1, STATUS_OK, 32'd100,  7'd1},
        '{OP_INSERT, TIME_MAX, 8'hFF,  ACT_ASSIGN_RIGHT, 16'hFFFF, 1'b1, STATUS_OK, TIME_MAX, 7'd2},
        '{OP_INSERT, 32'd0,    8'd0,   ACT_NONE,         16'h0000, 1'b1, STATUS_OK, TIME_MAX, 7'd3},
        '{OP_INSERT, 32'd100,  8'd3,   ACT_SKILL,        16'h0001, 1'b0, STATUS_OK, 32'd0,    7'd0},
        '{OP_INSERT, 32'd100,  8'd1,   ACT_AIM,          16'h8000, 1'b0, STATUS_OK, 32'd0,    7'd0},
        '{OP_INSERT, 32'd100,  8'd9,   ACT_NUKE,         16'h5A5A, 1'b0, STATUS_OK, 32'd0,    7'd0},
        '{OP_READ,   32'd100,  8'd0,   ACT_NONE,         16'h0000, 1'b0, STATUS_OK, 32'd0,    7'd0},
        '{OP_READ,   32'd50,   8'd0,   ACT_NONE,         16'h0000, 1'b1, STATUS_OK, TIME_MAX, 7'd6},
        '{OP_TAKE,   32'd0,    8'd0,   ACT_NONE,         16'h0000, 1'b0, STATUS_OK, 32'd0,    7'd0},
        '{OP_TAKE,   32'd99,   8'd0,   ACT_NONE,         16'h0000, 1'b1, STATUS_OK, TIME_MAX, 7'd5},
        '{OP_TAKE,   32'd100,  8'd0,   ACT_NONE,         16'h0000, 1'b0, STATUS_OK, 32'd0,    7'd0},
        '{OP_INSERT, 32'd200,  8'd5,   ACT_ASSIGN_ANY,   16'hA5A5, 1'b0, STATUS_OK, 32'd0,    7'd0},
        '{OP_INSERT, 32'd200,  8'd5,   ACT_ASSIGN_LEFT,  16'h00FF, 1'b0, STATUS_OK, 32'd0,    7'd0},
        '{OP_ERASE,  32'd150,  8'd0,   ACT_NONE,         16'h0000, 1'b1, STATUS_OK, 32'd0,    7'd0},
        '{OP_INSERT, 32'd300,  8'd2,   ACT_ASSIGN_RIGHT, 16'h7FFF, 1'b1, STATUS_OK, 32'd300,  7'd1},
        '{OP_ERASE,  32'd300,  8'd0,   ACT_NONE,         16'h0000, 1'b1, STATUS_OK, 32'd300,  7'd1},
        '{OP_TAKE,   TIME_MAX, 8'd0,   ACT_NONE,         16'h0000, 1'b0, STATUS_OK, 32'd0,    7'd0},
        '{OP_TAKE,   TIME_MAX, 8'd0,   ACT_NONE,         16'h0000, 1'b1, STATUS_OK, 32'd0,    7'd0}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cmd_valid   = 1'b0;
    logic        cmd_ready;
    logic [1:0]  operation   = 2'd0;
    logic [31:0] event_time  = 32'd0;
    logic [7:0]  player_id   = 8'd0;
    logic [2:0]  action_kind = 3'd0;
    logic [15:0] target_id   = 16'd0;
    logic        res_valid;
    logic        res_ready   = 1'b0;
    logic [31:0] out_time;
    logic [7:0]  out_player;
    logic [2:0]  out_action;
    logic [15:0] out_target;
    logic        no_entry;
    logic        last_of_run;
    logic        status;
    logic [31:0] latest_time;
    logic [6:0]  entry_count;

    // Shadow of the list, and the result items still owed by the block
    entry_t      list_q [DEPTH];
    int unsigned list_len    = 0;
    logic [31:0] list_latest = 32'd0;
    outcome_t    fresh_q [$];
    outcome_t    owed_q [$];

    int unsigned errors      = 0;
    int unsigned issued      = 0;
    int unsigned idle_cycles = 0;
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;

    time_sorted_event_list dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .operation   (operation),
        .event_time  (event_time),
        .player_id   (player_id),
        .action_kind (action_kind),
        .target_id   (target_id),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_time    (out_time),
        .out_player  (out_player),
        .out_action  (out_action),
        .out_target  (out_target),
        .no_entry    (no_entry),
        .last_of_run (last_of_run),
        .status      (status),
        .latest_time (latest_time),
        .entry_count (entry_count)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic bit precedes(entry_t x, entry_t y);
        return (x.ev_time < y.ev_time) || (x.ev_time == y.ev_time && x.player < y.player);
    endfunction

    function automatic void repair_latest();
        list_latest = (list_len != 0) ? list_q[list_len - 1].ev_time : 32'd0;
    endfunction

    // Apply one command to the shadow list and leave its result items in fresh_q.
    function automatic void advance_list(op_t op, entry_t item);
        int unsigned pos;
        int unsigned hits;
        outcome_t    blank;
        outcome_t    found;
        blank          = '0;
        blank.no_entry = 1'b1;
        found          = '0;
        fresh_q.delete();
        case (op)
            OP_INSERT:
            begin
                if (list_len >= DEPTH)
                begin
                    blank.status = STATUS_FULL;
                end
                else if (list_len == 0 || item.ev_time > list_latest)
                begin
                    list_q[list_len] = item;
                    list_latest      = item.ev_time;
                    list_len++;
                end
                else
                begin
                    pos = list_len;
                    for (int i = 0; i < list_len; i++)
                    begin
                        if (pos == list_len && precedes(item, list_q[i]))
                        begin
                            pos = i;
                        end
                    end
                    for (int i = list_len; i > pos; i--)
                    begin
                        list_q[i] = list_q[i - 1];
                    end
                    list_q[pos] = item;
                    list_len++;
                end
                fresh_q = {fresh_q, blank};
            end
            OP_TAKE:
            begin
                hits = 0;
                while (hits < list_len && hits < RESULT_CAP && list_q[hits].ev_time <= item.ev_time)
                begin
                    found.ent = list_q[hits];
                    fresh_q   = {fresh_q, found};
                    hits++;
                end
                if (hits != 0)
                begin
                    for (int i = 0; i < list_len - hits; i++)
                    begin
                        list_q[i] = list_q[i + hits];
                    end
                    list_len -= hits;
                    repair_latest();
                end
                else
                begin
                    fresh_q = {fresh_q, blank};
                end
            end
            OP_READ:
            begin
                for (int i = 0; i < list_len && fresh_q.size() < RESULT_CAP; i++)
                begin
                    if (list_q[i].ev_time > item.ev_time)
                    begin
                        break;
                    end
                    if (list_q[i].ev_time == item.ev_time)
                    begin
                        found.ent = list_q[i];
                        fresh_q   = {fresh_q, found};
                    end
                end
                if (fresh_q.size() == 0)
                begin
                    fresh_q = {fresh_q, blank};
                end
            end
            default:
            begin
                hits = 0;
                while (hits < list_len && list_q[hits].ev_time <= item.ev_time)
                begin
                    hits++;
                end
                list_len = hits;
                repair_latest();
                fresh_q = {fresh_q, blank};
            end
        endcase
        foreach (fresh_q[k])
        begin
            fresh_q[k].last   = (k == fresh_q.size() - 1);
            fresh_q[k].latest = list_latest;
            fresh_q[k].count  = 7'(list_len);
        end
    endfunction

    function automatic logic [31:0] pick_stored_time();
        return (list_len != 0) ? list_q[$urandom_range(0, list_len - 1)].ev_time : $urandom;
    endfunction

    // Present one command, hold it until accepted, then book its result items.
    task automatic issue(input op_t op, input logic [31:0] t, input logic [7:0] p,
                         input logic [2:0] a, input logic [15:0] g,
                         input bit typed, input outcome_t typed_res);
        int unsigned gap;
        entry_t      item;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        operation   <= op;
        event_time  <= t;
        player_id   <= p;
        action_kind <= a;
        target_id   <= g;
        do @(posedge clk); while (!cmd_ready);
        item = '{ev_time: t, player: p, action: a, target: g};
        advance_list(op, item);
        if (typed)
        begin
            owed_q = {owed_q, typed_res};
        end
        else
        begin
            foreach (fresh_q[k])
            begin
                owed_q = {owed_q, fresh_q[k]};
            end
        end
        issued++;
    endtask

    // Hold the command channel low until every owed item has come back.
    task automatic drain_results();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (owed_q.size() != 0);
    endtask

    task automatic fill_episode();
        logic [31:0] base;
        int unsigned extra;
        base  = ($urandom_range(0, 3) == 0) ? (TIME_MAX - 32'd20) : $urandom;
        extra = $urandom_range(1, 3);
        while (list_len < DEPTH)
        begin
            issue(OP_INSERT, base + $urandom_range(0, 30), 8'($urandom_range(0, 3)),
                  3'($urandom_range(0, 7)), 16'($urandom), 1'b0, '0);
        end
        // push past full: these must be refused
        repeat (extra)
        begin
            issue(OP_INSERT, $urandom, 8'($urandom), 3'($urandom_range(0, 7)),
                  16'($urandom), 1'b0, '0);
        end
        issue(OP_READ, pick_stored_time(), 8'd0, ACT_NONE, 16'd0, 1'b0, '0);
        issue(OP_TAKE, $urandom_range(0, 1) ? TIME_MAX : base + 32'd15, 8'd0, ACT_NONE,
              16'd0, 1'b0, '0);
    endtask

    task automatic mixed_episode(ref logic [31:0] base);
        int unsigned n;
        int unsigned roll;
        n = $urandom_range(10, 25);
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                issue(OP_INSERT, base + $urandom_range(0, 12), 8'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)), 16'($urandom), 1'b0, '0);
                base += $urandom_range(0, 2);
            end
            else if (roll < 72)
            begin
                issue(OP_TAKE, $urandom_range(0, 1) ? pick_stored_time() : base - $urandom_range(0, 8),
                      8'($urandom), 3'($urandom_range(0, 7)), 16'($urandom), 1'b0, '0);
            end
            else if (roll < 88)
            begin
                issue(OP_READ, ($urandom_range(0, 3) != 0) ? pick_stored_time() : $urandom,
                      8'($urandom), 3'($urandom_range(0, 7)), 16'($urandom), 1'b0, '0);
            end
            else if (roll < 94)
            begin
                issue(OP_ERASE, $urandom_range(0, 1) ? pick_stored_time() : base + $urandom_range(0, 8),
                      8'($urandom), 3'($urandom_range(0, 7)), 16'($urandom), 1'b0, '0);
            end
            else
            begin
                issue(op_t'($urandom_range(0, 3)), $urandom, 8'($urandom),
                      3'($urandom_range(0, 7)), 16'($urandom), 1'b0, '0);
            end
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ERROR %s: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Result side: random stalls, then check each accepted item.
    initial
    begin
        int unsigned stall;
        outcome_t    want;
        @(posedge rst_n);
        forever
        begin
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            if (owed_q.size() == 0)
            begin
                $display("%0t ERROR unexpected result item: time %0h no_entry %0b", $time,
                         out_time, no_entry);
                errors++;
            end
            else
            begin
                want = owed_q.pop_front();
                check_field("out_time", want.ent.ev_time, out_time);
                check_field("out_player", 32'(want.ent.player), 32'(out_player));
                check_field("out_action", 32'(want.ent.action), 32'(out_action));
                check_field("out_target", 32'(want.ent.target), 32'(out_target));
                check_field("no_entry", 32'(want.no_entry), 32'(no_entry));
                check_field("last_of_run", 32'(want.last), 32'(last_of_run));
                check_field("status", 32'(want.status), 32'(status));
                check_field("latest_time", want.latest, latest_time);
                check_field("entry_count", 32'(want.count), 32'(entry_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STUCK_LIMIT)
        begin
            $display("%0t ERROR no handshake for %0d cycles", $time, STUCK_LIMIT);
            $display("tb_time_sorted_event_list failed");
            $finish;
        end
    end

    initial
    begin
        outcome_t    ack;
        logic [31:0] base;
        bit          first;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[r])
        begin
            ack        = '0;
            ack.no_entry = 1'b1;
            ack.last   = 1'b1;
            ack.status = SCRIPT[r].status;
            ack.latest = SCRIPT[r].latest;
            ack.count  = SCRIPT[r].count;
            issue(SCRIPT[r].op, SCRIPT[r].ev_time, SCRIPT[r].player, SCRIPT[r].action,
                  SCRIPT[r].target, SCRIPT[r].typed, ack);
        end

        base  = $urandom;
        first = 1'b1;
        while (issued < SCRIPT_LEN + RANDOM_ITEMS)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (first || $urandom_range(0, 99) < 15)
            begin
                fill_episode();
                if (first)
                begin
                    drain_results();
                end
                first = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    base = $urandom_range(0, 1) ? 32'd0 : $urandom;
                end
                mixed_episode(base);
                if ($urandom_range(0, 4) == 0)
                begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (DEPTH + 16) @(posedge clk);
        if (errors == 0 && owed_q.size() == 0)
        begin
            $display("tb_time_sorted_event_list passed");
        end
        else
        begin
            $display("tb_time_sorted_event_list failed");
        end
        $finish;
    end

endmodule
